### rtl/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg
// Shared types and constants of the harmony pitch shifter.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int SAMPLE_W = 24;
  localparam int FRAC_W   = 16;
  localparam int RATIO_W  = 18;
  localparam int ACC_W    = 42;
  localparam int MUL_W    = 28;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int HARM_W   = 26;

  // pitch ratios 2^(n/12) with 16 fraction bits: third, fifth, octave
  localparam logic [RATIO_W-1:0] VOICE_RATIO [3] = '{18'd82570, 18'd98193, 18'd131072};

  // floor(u / 3) = (u * DIV3_M) >> DIV3_SH for u below 2^27
  localparam logic [MUL_W-1:0] DIV3_M  = 28'd89478486;
  localparam int               DIV3_SH = 28;
  // bias that keeps the dividend positive, and its third
  localparam logic [26:0]       DIV_BIAS   = 27'd50331648;
  localparam logic [HARM_W-1:0] DIV_BIAS_Q = 26'd16777216;

  localparam logic signed [HARM_W:0] SAMPLE_MAX = 27'sd8388607;
  localparam logic signed [HARM_W:0] SAMPLE_MIN = -27'sd8388608;

  localparam logic [0:0] REG_BYPASS      = 1'b0;
  localparam logic [0:0] REG_VOICE_COUNT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RD1,
    ST_RD2,
    ST_DIFF,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                    en;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

endpackage

### rtl/hps_mul.sv
// ----------------------------------------------------------------------------
// hps_mul
// Shared registered signed multiplier for interpolation and divide by three.
// ----------------------------------------------------------------------------
module hps_mul (
  input  logic                                 clk,
  input  hps_pkg::mul_req_t                    req,
  output logic signed [hps_pkg::PROD_W-1:0]    prod
);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= $signed(req.a) * $signed(req.b);
    end
  end

endmodule

### rtl/harmony_pitch_shifter_top.sv
// ----------------------------------------------------------------------------
// harmony_pitch_shifter_top
// Two-channel delay ring pitch shifter with up to three interpolated voices.
// ----------------------------------------------------------------------------
// A request is accepted and written to the ring. Then, for each active voice,
// it takes two reads, a difference, a multiply and an accumulate step. Then
// comes the divide step, which always runs and for two voices goes through the
// shared multiplier. Last come a finish step and the output step, which holds
// while an unread result sits in the output register; a bypassed request goes
// straight to the output step. The input is ready again in the cycle after the
// output register loads. The single-port sample ring sets this sequence: one
// write, then two reads per voice, each read registered. The input is not
// ready while a request is in work. The ring needs no clearing pass after reset:
// each channel tracks its write index and a wrapped flag, and entries not yet written read as zero.
module harmony_pitch_shifter_top #(
  parameter int DELAY_DEPTH = 4096,
  parameter int VOICE_SLOTS = 3,
  parameter int CHANNELS    = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // sample_in[23:0]
  input  logic        s_axis_tuser,   // channel[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // sample_out[23:0]
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [1:0]  cfg_data
);

  localparam int IW        = $clog2(DELAY_DEPTH);
  localparam int PW        = IW + hps_pkg::FRAC_W;
  localparam int MEM_DEPTH = CHANNELS * DELAY_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int VW        = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
  localparam logic [PW:0]   WRAP  = (PW + 1)'(DELAY_DEPTH) << hps_pkg::FRAC_W;
  localparam logic [IW-1:0] LAST  = IW'(DELAY_DEPTH - 1);
  localparam logic [AW-1:0] BASE1 = AW'(DELAY_DEPTH);

  hps_pkg::state_t state, state_next;

  logic                                   bypass;
  logic [1:0]                             voice_count;
  logic                                   ch_r;
  logic signed [hps_pkg::SAMPLE_W-1:0]    dry_r;
  logic [1:0]                             n_r;
  logic                                   pass_r;
  logic [VW-1:0]                          vcnt;
  logic signed [hps_pkg::ACC_W-1:0]       acc;
  logic signed [hps_pkg::SAMPLE_W-1:0]    s1_r;
  logic signed [hps_pkg::SAMPLE_W:0]      diff_r;
  logic                                   ok1_r, ok2_r;
  logic [hps_pkg::SAMPLE_W-1:0]           mem_q;
  logic signed [hps_pkg::HARM_W-1:0]      h_r;
  logic                                   out_valid;
  logic [hps_pkg::SAMPLE_W-1:0]           out_data;

  logic [IW-1:0] widx    [CHANNELS];
  logic          wrapped [CHANNELS];
  logic [PW-1:0] pos     [CHANNELS][VOICE_SLOTS];

  logic [hps_pkg::SAMPLE_W-1:0] mem [MEM_DEPTH];
  logic                         mem_we, mem_re;
  logic [AW-1:0]                mem_addr;

  hps_pkg::mul_req_t                    mul_req;
  logic signed [hps_pkg::PROD_W-1:0]    prod;

  hps_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  // current channel and voice
  logic [PW-1:0]               pos_cur;
  logic [PW:0]                 pos_sum, pos_wrapped;
  logic [IW-1:0]               i1, i2, w_cur;
  logic [hps_pkg::FRAC_W-1:0]  frac;
  logic [AW-1:0]               base;
  logic                        valid1, valid2;
  logic [1:0]                  n_in;
  logic                        pass_in;
  logic                        load_out;
  logic [26:0]                 div_u;
  logic signed [hps_pkg::SAMPLE_W-1:0] s_masked;
  logic signed [hps_pkg::HARM_W:0]     total;
  logic [hps_pkg::SAMPLE_W-1:0]        sat_val;

  always_comb begin
    pos_cur     = pos[ch_r][vcnt];
    i1          = pos_cur[PW-1:hps_pkg::FRAC_W];
    i2          = (i1 == LAST) ? '0 : i1 + 1'b1;
    frac        = pos_cur[hps_pkg::FRAC_W-1:0];
    w_cur       = widx[ch_r];
    base        = ch_r ? BASE1 : '0;
    // entries are written in ring order, so an entry was written when the
    // ring has wrapped or it lies at or below the current write index
    valid1      = wrapped[ch_r] || (i1 <= w_cur);
    valid2      = wrapped[ch_r] || (i2 <= w_cur);
    pos_sum     = {1'b0, pos_cur} + (PW + 1)'(hps_pkg::VOICE_RATIO[2'(vcnt)]);
    pos_wrapped = (pos_sum >= WRAP) ? pos_sum - WRAP : pos_sum;
    s_masked    = ok2_r ? $signed(mem_q) : '0;
    div_u       = 27'(acc >>> hps_pkg::FRAC_W) + hps_pkg::DIV_BIAS;
    load_out    = !out_valid || m_axis_tready;
    total       = (hps_pkg::HARM_W + 1)'(dry_r) + (hps_pkg::HARM_W + 1)'(h_r);
    if (total > hps_pkg::SAMPLE_MAX) begin
      sat_val = hps_pkg::SAMPLE_MAX[hps_pkg::SAMPLE_W-1:0];
    end else if (total < hps_pkg::SAMPLE_MIN) begin
      sat_val = hps_pkg::SAMPLE_MIN[hps_pkg::SAMPLE_W-1:0];
    end else begin
      sat_val = total[hps_pkg::SAMPLE_W-1:0];
    end
    if (voice_count == 2'd0) begin
      n_in = 2'd1;
    end else if (32'(voice_count) > VOICE_SLOTS) begin
      n_in = 2'(VOICE_SLOTS);
    end else begin
      n_in = voice_count;
    end
    pass_in = bypass || (32'(s_axis_tuser) >= CHANNELS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state, ring port and multiplier requests
  always_comb begin
    state_next    = state;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = base + AW'(w_cur);
    mul_req.en    = 1'b0;
    mul_req.a     = hps_pkg::MUL_W'({1'b0, frac});
    mul_req.b     = hps_pkg::MUL_W'(diff_r);
    s_axis_tready = 1'b0;
    unique case (state)
      hps_pkg::ST_IDLE: begin
        s_axis_tready = !rst;
        if (s_axis_tvalid && !rst) begin
          state_next = pass_in ? hps_pkg::ST_OUT : hps_pkg::ST_WRITE;
        end
      end
      hps_pkg::ST_WRITE: begin
        mem_we     = 1'b1;
        state_next = hps_pkg::ST_RD1;
      end
      hps_pkg::ST_RD1: begin
        mem_re     = 1'b1;
        mem_addr   = base + AW'(i1);
        state_next = hps_pkg::ST_RD2;
      end
      hps_pkg::ST_RD2: begin
        mem_re     = 1'b1;
        mem_addr   = base + AW'(i2);
        state_next = hps_pkg::ST_DIFF;
      end
      hps_pkg::ST_DIFF: begin
        state_next = hps_pkg::ST_MUL;
      end
      hps_pkg::ST_MUL: begin
        mul_req.en = 1'b1;
        state_next = hps_pkg::ST_ACC;
      end
      hps_pkg::ST_ACC: begin
        state_next = (vcnt == VW'(n_r - 2'd1)) ? hps_pkg::ST_DIV : hps_pkg::ST_RD1;
      end
      hps_pkg::ST_DIV: begin
        // divide by three only for two voices
        mul_req.en = (n_r == 2'd2);
        mul_req.a  = hps_pkg::MUL_W'(div_u);
        mul_req.b  = hps_pkg::DIV3_M;
        state_next = hps_pkg::ST_FIN;
      end
      hps_pkg::ST_FIN: begin
        state_next = hps_pkg::ST_OUT;
      end
      hps_pkg::ST_OUT: begin
        if (load_out) begin
          state_next = hps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= dry_r;
    end
    if (mem_re) begin
      mem_q <= mem[mem_addr];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bypass      <= 1'b0;
      voice_count <= 2'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hps_pkg::REG_BYPASS:      bypass      <= cfg_data[0];
        hps_pkg::REG_VOICE_COUNT: voice_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      hps_pkg::ST_IDLE: begin
        ch_r   <= s_axis_tuser;
        dry_r  <= $signed(s_axis_tdata);
        n_r    <= n_in;
        pass_r <= pass_in;
        vcnt   <= '0;
        acc    <= '0;
      end
      hps_pkg::ST_RD1: begin
        ok1_r <= valid1;
      end
      hps_pkg::ST_RD2: begin
        ok2_r <= valid2;
        s1_r  <= ok1_r ? $signed(mem_q) : '0;
      end
      hps_pkg::ST_DIFF: begin
        diff_r <= (hps_pkg::SAMPLE_W + 1)'(s_masked) - (hps_pkg::SAMPLE_W + 1)'(s1_r);
      end
      hps_pkg::ST_ACC: begin
        acc  <= acc + (hps_pkg::ACC_W'(s1_r) <<< hps_pkg::FRAC_W)
                    + $signed(prod[hps_pkg::ACC_W-1:0]);
        if (vcnt != VW'(n_r - 2'd1)) begin
          vcnt <= vcnt + 1'b1;
        end
      end
      hps_pkg::ST_FIN: begin
        priority case (n_r)
          2'd1:    h_r <= hps_pkg::HARM_W'(acc >>> (hps_pkg::FRAC_W + 1));
          2'd2:    h_r <= $signed(prod[hps_pkg::DIV3_SH +: hps_pkg::HARM_W]
                                  - hps_pkg::DIV_BIAS_Q);
          default: h_r <= hps_pkg::HARM_W'(acc >>> (hps_pkg::FRAC_W + 2));
        endcase
      end
      default: ;
    endcase
  end

  // channel state: read positions, write index and wrapped flag
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        widx[c]    <= '0;
        wrapped[c] <= 1'b0;
        for (int v = 0; v < VOICE_SLOTS; v++) begin
          pos[c][v] <= '0;
        end
      end
    end else begin
      if (state == hps_pkg::ST_ACC) begin
        pos[ch_r][vcnt] <= pos_wrapped[PW-1:0];
      end
      if (state == hps_pkg::ST_OUT && load_out && !pass_r) begin
        widx[ch_r] <= (w_cur == LAST) ? '0 : w_cur + 1'b1;
        if (w_cur == LAST) begin
          wrapped[ch_r] <= 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == hps_pkg::ST_OUT && load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == hps_pkg::ST_OUT && load_out) begin
      out_data <= pass_r ? dry_r : sat_val;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready while a request is in work");

  a_voice_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != hps_pkg::ST_IDLE && !pass_r) |-> (2'(vcnt) < n_r))
    else $error("voice counter beyond active voice count");

  a_pos_in_ring: assert property (@(posedge clk) disable iff (rst)
    (state == hps_pkg::ST_RD1) |-> ({1'b0, pos_cur} < WRAP))
    else $error("read position outside the ring");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == hps_pkg::ST_OUT))
    else $error("result loaded outside the output step");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams signed samples on both channels through the harmony pitch shifter
// under every bypass and voice count setting. A scoreboard keeps its own delay
// rings and voice read positions, predicts each output sample and checks the
// outputs in order. Both stream sides idle at random; a closing run on one
// channel feeds samples back to back with all three voices active.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RING_SIZE = 4096;
  localparam int VOICES    = 3;
  localparam int SOAK_LEN  = 75;
  localparam int SEG_LEN   = 55;
  localparam int SEGMENTS  = 6;

  localparam bit signed [23:0] SMP_MAX = 24'sh7FFFFF;
  localparam bit signed [23:0] SMP_MIN = 24'sh800000;

  // 2^(n/12) for +4, +7 and +12 semitones, 16 fraction bits
  localparam bit [17:0] PITCH_STEP [VOICES] = '{18'd82570, 18'd98193, 18'd131072};

  class harmony_predictor;
    bit signed [23:0] ring [2][RING_SIZE];
    bit [11:0]        wr_idx [2];
    bit [27:0]        read_pos [2][VOICES];
    bit               bypass;
    bit [1:0]         voice_count;
    bit [23:0]        expected_out [$];
    int               errors;
    int               checked;
    int               passed_through;
    int               stray;

    function new();
      bypass      = 1'b0;
      voice_count = 2'd1;
    endfunction

    function void set_reg(logic [0:0] idx, logic [1:0] val);
      if (idx == hps_pkg::REG_BYPASS) bypass = val[0];
      else voice_count = val;
    endfunction

    function void note_failure(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] %s", $time, msg);
    endfunction

    function void accept_sample(bit ch, bit signed [23:0] dry);
      int     n;
      bit [11:0] w;
      bit [11:0] i1;
      bit [11:0] i2;
      longint fr;
      longint s1;
      longint s2;
      longint voice_sum;
      longint den;
      longint harm;
      longint total;
      if (bypass) begin
        passed_through++;
        expected_out.push_back(dry);
        return;
      end
      n = (voice_count == 2'd0) ? 1 : int'(voice_count);
      w = wr_idx[ch];
      ring[ch][w] = dry;
      voice_sum = 0;
      for (int v = 0; v < n; v++) begin
        i1 = read_pos[ch][v][27:16];
        i2 = i1 + 12'd1;
        fr = longint'(read_pos[ch][v][15:0]);
        s1 = ring[ch][i1];
        s2 = ring[ch][i2];
        voice_sum += s1 * 65536 + fr * (s2 - s1);
        // ring size is a power of two, so the wrap is the dropped carry
        read_pos[ch][v] = read_pos[ch][v] + PITCH_STEP[v];
      end
      den  = longint'(n + 1) * 65536;
      harm = voice_sum / den;
      if ((voice_sum % den) != 0 && voice_sum < 0) harm--;
      total = longint'(dry) + harm;
      if (total > longint'(SMP_MAX)) total = longint'(SMP_MAX);
      if (total < longint'(SMP_MIN)) total = longint'(SMP_MIN);
      wr_idx[ch] = w + 12'd1;
      expected_out.push_back(total[23:0]);
    endfunction

    function void check_sample_out(logic [23:0] got);
      bit [23:0] want;
      if (expected_out.size() == 0) begin
        stray++;
        note_failure($sformatf("output %0d with no request pending", $signed(got)));
        return;
      end
      want = expected_out.pop_front();
      checked++;
      if (got !== want)
        note_failure($sformatf("sample_out mismatch: expected %0d got %0d",
                               $signed(want), $signed(got)));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // sample_in[23:0]
  logic        s_axis_tuser = 1'b0; // channel[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // sample_out[23:0]
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = hps_pkg::REG_BYPASS;
  logic [1:0]  cfg_data = 2'd0;

  int tx_max_gap = 7;
  int rx_max_stall = 7;
  int rx_hold_cycles = 0;

  harmony_predictor sb = new();

  harmony_pitch_shifter_top DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit signed [23:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return 24'($signed($urandom_range(0, 32)) - 16);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_sample(bit ch, bit signed [23:0] smp);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= ch;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sb.accept_sample(ch, smp);
  endtask

  // sender pauses until every pending request has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_out.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // receiver side
  initial begin
    int stall;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, rx_max_stall);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      sb.check_sample_out(m_axis_tdata);
    end
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes and saturation at reset settings (one voice)
    send_sample(1'b0, SMP_MAX);
    send_sample(1'b0, SMP_MAX);
    send_sample(1'b0, SMP_MIN);
    send_sample(1'b0, SMP_MIN);
    send_sample(1'b0, 24'sd0);
    send_sample(1'b0, -24'sd1);
    send_sample(1'b1, SMP_MIN);
    send_sample(1'b1, SMP_MAX);
    send_sample(1'b1, 24'sd1);
    drain_results();
    // a voice count of zero acts as one
    write_reg(hps_pkg::REG_VOICE_COUNT, 2'd0);
    send_sample(1'b0, 24'sh400000);
    send_sample(1'b0, -24'sh400000);
    send_sample(1'b1, SMP_MAX);
    drain_results();
    write_reg(hps_pkg::REG_VOICE_COUNT, 2'd2);
    send_sample(1'b0, SMP_MAX);
    send_sample(1'b0, SMP_MIN);
    send_sample(1'b1, SMP_MAX);
    drain_results();
    write_reg(hps_pkg::REG_VOICE_COUNT, 2'd3);
    send_sample(1'b0, SMP_MAX);
    send_sample(1'b0, SMP_MAX);
    send_sample(1'b0, SMP_MIN);
    send_sample(1'b1, -24'sd1);
    drain_results();
    // bypass freezes rings and positions
    write_reg(hps_pkg::REG_BYPASS, 2'd1);
    send_sample(1'b0, SMP_MAX);
    send_sample(1'b0, SMP_MIN);
    send_sample(1'b1, 24'sd5);
    send_sample(1'b1, 24'sh123456);
    drain_results();
    // only bit 0 of the bypass register counts
    write_reg(hps_pkg::REG_BYPASS, 2'd2);
    send_sample(1'b0, 24'sd7);
    send_sample(1'b1, -24'sd7);
    drain_results();

    // random segments, each with its own settings and idling
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 0) begin
        write_reg(hps_pkg::REG_VOICE_COUNT, 2'd3);
        write_reg(hps_pkg::REG_BYPASS, 2'd0);
      end else begin
        write_reg(hps_pkg::REG_VOICE_COUNT, 2'($urandom_range(0, 3)));
        write_reg(hps_pkg::REG_BYPASS, ($urandom_range(0, 5) == 0) ? 2'd1 : 2'd0);
      end
      tx_max_gap   = (seg == 1 || seg == 2) ? 0 : 7;
      rx_max_stall = (seg == 1) ? 0 : 7;
      // long receiver hold so the block backs up into the input
      if (seg == 2) rx_hold_cycles = 250;
      for (int k = 0; k < SEG_LEN; k++)
        send_sample(1'($urandom_range(0, 1)), pick_sample());
      drain_results();
    end

    // back-to-back run on one channel with all three voices
    write_reg(hps_pkg::REG_BYPASS, 2'd0);
    write_reg(hps_pkg::REG_VOICE_COUNT, 2'd3);
    tx_max_gap   = 0;
    rx_max_stall = 0;
    for (int k = 0; k < SOAK_LEN; k++)
      send_sample(1'b0, pick_sample());
    tx_max_gap   = 7;
    rx_max_stall = 7;
    for (int k = 0; k < 20; k++)
      send_sample(1'($urandom_range(0, 1)), pick_sample());
    s_axis_tvalid <= 1'b0;

    while (sb.expected_out.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.expected_out.size() != 0)
      sb.note_failure($sformatf("%0d requests never answered", sb.expected_out.size()));

    $display("checked %0d output samples (%0d in bypass), voice counts 0 to 3, both channels",
             sb.checked, sb.passed_through);
    $display("run of %0d samples back to back on channel 0 with three voices; %0d errors",
             SOAK_LEN, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/hps_pkg.sv
rtl/hps_mul.sv
rtl/harmony_pitch_shifter_top.sv
tb/sv/tb_top.sv
